FILE: design/blt_pkg.sv
// Shared constants, character codes and item types of the boot argument line tokenizer.
package blt_pkg;

    localparam int MAX_ARGS   = 20;
    localparam int LINE_BYTES = 256;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_EQUALS  = 8'h3d;
    localparam logic [7:0] CHAR_MINUS   = 8'h2d;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_LOWER_X = 8'h78;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;

    localparam logic [31:0] DEC_BASE = 32'd10;

    // Input item as held in the input register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    // One reported token
    typedef struct packed {
        logic        is_program_name;
        logic [4:0]  arg_index;
        logic [7:0]  name_start;
        logic [7:0]  name_length;
        logic        has_value;
        logic [7:0]  value_start;
        logic [7:0]  value_length;
        logic [31:0] value_number;
    } result_t;

endpackage

FILE: design/blt_scan.sv
// Token scanner: line state registers and the per-byte next-state and result logic.
module blt_scan (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  blt_pkg::in_item_t item,
    output blt_pkg::result_t res,
    output logic             res_valid
);

    localparam logic [1:0] PH_PROG  = 2'd0;
    localparam logic [1:0] PH_WAIT  = 2'd1;
    localparam logic [1:0] PH_TOKEN = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    localparam logic [7:0] LAST_POS = 8'(blt_pkg::LINE_BYTES - 1);
    localparam logic [4:0] ARG_MAX  = 5'(blt_pkg::MAX_ARGS);

    logic [1:0]  phase_reg, phase_next;
    logic [4:0]  arg_count_reg, arg_count_next;
    logic [7:0]  byte_pos_reg, byte_pos_next;
    logic [7:0]  token_start_reg, token_start_next;
    logic [7:0]  name_len_reg, name_len_next;
    logic        name_closed_reg, name_closed_next;
    logic        value_pending_reg, value_pending_next;
    logic        value_active_reg, value_active_next;
    logic        value_seen_reg, value_seen_next;
    logic [7:0]  seg_start_reg, seg_start_next;
    logic [7:0]  seg_len_reg, seg_len_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] acc_neg_reg, acc_neg_next;   // always the two's complement of acc
    logic        negative_reg, negative_next;
    logic        hex_base_reg, hex_base_next;
    logic [1:0]  prefix_step_reg, prefix_step_next;

    logic        emit_prog, emit_arg, overlong, pos_adv, take, add_digit, feed_done;
    logic [7:0]  c;
    logic [31:0] digit;
    logic [31:0] acc_scaled, acc_neg_scaled;
    logic [31:0] acc_x10, acc_neg_x10;
    logic [31:0] acc_cur, acc_neg_cur;
    logic        hex_cur;

    assign c = item.data_byte;

    // a byte right after '=' opens a fresh segment, so scale from zero then
    assign acc_cur     = value_pending_reg ? '0 : acc_reg;
    assign acc_neg_cur = value_pending_reg ? '0 : acc_neg_reg;
    assign hex_cur     = value_pending_reg ? 1'b0 : hex_base_reg;

    always_comb begin
        phase_next         = phase_reg;
        arg_count_next     = arg_count_reg;
        byte_pos_next      = byte_pos_reg;
        token_start_next   = token_start_reg;
        name_len_next      = name_len_reg;
        name_closed_next   = name_closed_reg;
        value_pending_next = value_pending_reg;
        value_active_next  = value_active_reg;
        value_seen_next    = value_seen_reg;
        seg_start_next     = seg_start_reg;
        seg_len_next       = seg_len_reg;
        acc_next           = acc_reg;
        acc_neg_next       = acc_neg_reg;
        negative_next      = negative_reg;
        hex_base_next      = hex_base_reg;
        prefix_step_next   = prefix_step_reg;
        emit_prog          = 1'b0;
        emit_arg           = 1'b0;
        overlong           = 1'b0;
        pos_adv            = 1'b0;
        take               = 1'b0;
        add_digit          = 1'b0;
        feed_done          = 1'b0;
        res                = '0;

        if (phase_reg != PH_DONE) begin
            if (byte_pos_reg >= LAST_POS) begin
                overlong = 1'b1;
                if (phase_reg == PH_PROG) begin
                    emit_prog = 1'b1;
                end else if (phase_reg == PH_TOKEN) begin
                    emit_arg = 1'b1;
                end
            end else begin
                pos_adv = 1'b1;
                unique case (phase_reg)
                    PH_PROG: begin
                        if (c == blt_pkg::CHAR_SPACE) begin
                            emit_prog = 1'b1;
                        end else begin
                            name_len_next = name_len_reg + 8'd1;
                            emit_prog     = item.last_byte;
                        end
                    end
                    PH_WAIT: begin
                        // open a fresh token at this offset
                        token_start_next   = byte_pos_reg;
                        name_len_next      = '0;
                        name_closed_next   = 1'b0;
                        value_pending_next = 1'b0;
                        value_active_next  = 1'b0;
                        value_seen_next    = 1'b0;
                        seg_start_next     = '0;
                        seg_len_next       = '0;
                        acc_next           = '0;
                        acc_neg_next       = '0;
                        negative_next      = 1'b0;
                        hex_base_next      = 1'b0;
                        prefix_step_next   = '0;
                        if (c == blt_pkg::CHAR_SPACE) begin
                            emit_arg = 1'b1;
                        end else begin
                            take       = 1'b1;
                            phase_next = PH_TOKEN;
                            emit_arg   = item.last_byte;
                        end
                    end
                    PH_TOKEN: begin
                        if (c == blt_pkg::CHAR_SPACE) begin
                            emit_arg = 1'b1;
                        end else begin
                            take     = 1'b1;
                            emit_arg = item.last_byte;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (take) begin
            if (value_pending_next) begin
                seg_start_next     = byte_pos_reg;
                seg_len_next       = '0;
                acc_next           = '0;
                acc_neg_next       = '0;
                negative_next      = 1'b0;
                hex_base_next      = 1'b0;
                prefix_step_next   = '0;
                value_seen_next    = 1'b1;
                value_active_next  = 1'b1;
                value_pending_next = 1'b0;
            end
            if (c == blt_pkg::CHAR_EQUALS) begin
                name_closed_next   = 1'b1;
                value_active_next  = 1'b0;
                value_pending_next = 1'b1;
            end else begin
                if (!name_closed_next) begin
                    name_len_next = name_len_next + 8'd1;
                end
                if (value_active_next) begin
                    seg_len_next = seg_len_next + 8'd1;
                    if (prefix_step_next == 2'd0) begin
                        prefix_step_next = 2'd1;
                        if (c == blt_pkg::CHAR_MINUS) begin
                            negative_next = 1'b1;
                            feed_done     = 1'b1;
                        end
                    end
                    if (!feed_done) begin
                        if (prefix_step_next == 2'd1) begin
                            if (c == blt_pkg::CHAR_ZERO) begin
                                acc_next         = acc_x10;
                                acc_neg_next     = acc_neg_x10;
                                prefix_step_next = 2'd2;
                            end else begin
                                add_digit = 1'b1;
                            end
                        end else if (prefix_step_next == 2'd2 && c == blt_pkg::CHAR_LOWER_X) begin
                            hex_base_next    = 1'b1;
                            prefix_step_next = 2'd3;
                        end else begin
                            add_digit = 1'b1;
                        end
                    end
                end
            end
        end

        // digit step: both signs track together so no negate sits after the add
        if (add_digit) begin
            acc_next         = acc_scaled + digit;
            acc_neg_next     = acc_neg_scaled - digit;
            prefix_step_next = 2'd3;
        end

        if (emit_prog || emit_arg) begin
            res.is_program_name = emit_prog;
            res.arg_index       = emit_prog ? 5'd0 : arg_count_reg;
            res.name_start      = token_start_next;
            res.name_length     = name_len_next;
            if (emit_arg && value_seen_next) begin
                res.has_value    = 1'b1;
                res.value_start  = seg_start_next;
                res.value_length = seg_len_next;
                res.value_number = negative_next ? acc_neg_next : acc_next;
            end
        end

        if (emit_prog) begin
            phase_next = PH_WAIT;
        end else if (emit_arg) begin
            arg_count_next = arg_count_reg + 5'd1;
            phase_next     = (arg_count_next >= ARG_MAX) ? PH_DONE : PH_WAIT;
        end
        if (overlong) begin
            phase_next = PH_DONE;
        end
        if (pos_adv) begin
            byte_pos_next = byte_pos_reg + 8'd1;
        end

        // line end: back to the reset state for the next line
        if (item.last_byte) begin
            phase_next         = PH_PROG;
            arg_count_next     = '0;
            byte_pos_next      = '0;
            token_start_next   = '0;
            name_len_next      = '0;
            name_closed_next   = 1'b0;
            value_pending_next = 1'b0;
            value_active_next  = 1'b0;
            value_seen_next    = 1'b0;
            seg_start_next     = '0;
            seg_len_next       = '0;
            acc_next           = '0;
            acc_neg_next       = '0;
            negative_next      = 1'b0;
            hex_base_next      = 1'b0;
            prefix_step_next   = '0;
        end
    end

    // base scaling of the value accumulated before this byte
    always_comb begin
        acc_x10        = (acc_cur << 3) + (acc_cur << 1);
        acc_neg_x10    = (acc_neg_cur << 3) + (acc_neg_cur << 1);
        acc_scaled     = hex_cur ? (acc_cur << 4) : acc_x10;
        acc_neg_scaled = hex_cur ? (acc_neg_cur << 4) : acc_neg_x10;
        if (c < blt_pkg::CHAR_ZERO + 8'(blt_pkg::DEC_BASE)) begin
            digit = {24'd0, c} - {24'd0, blt_pkg::CHAR_ZERO};
        end else begin
            digit = {24'd0, c} - {24'd0, blt_pkg::CHAR_LOWER_A} + blt_pkg::DEC_BASE;
        end
    end

    assign res_valid = fire && (emit_prog || emit_arg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_PROG;
            arg_count_reg     <= '0;
            byte_pos_reg      <= '0;
            token_start_reg   <= '0;
            name_len_reg      <= '0;
            name_closed_reg   <= 1'b0;
            value_pending_reg <= 1'b0;
            value_active_reg  <= 1'b0;
            value_seen_reg    <= 1'b0;
            seg_start_reg     <= '0;
            seg_len_reg       <= '0;
            acc_reg           <= '0;
            acc_neg_reg       <= '0;
            negative_reg      <= 1'b0;
            hex_base_reg      <= 1'b0;
            prefix_step_reg   <= '0;
        end else if (fire) begin
            phase_reg         <= phase_next;
            arg_count_reg     <= arg_count_next;
            byte_pos_reg      <= byte_pos_next;
            token_start_reg   <= token_start_next;
            name_len_reg      <= name_len_next;
            name_closed_reg   <= name_closed_next;
            value_pending_reg <= value_pending_next;
            value_active_reg  <= value_active_next;
            value_seen_reg    <= value_seen_next;
            seg_start_reg     <= seg_start_next;
            seg_len_reg       <= seg_len_next;
            acc_reg           <= acc_next;
            acc_neg_reg       <= acc_neg_next;
            negative_reg      <= negative_next;
            hex_base_reg      <= hex_base_next;
            prefix_step_reg   <= prefix_step_next;
        end
    end

    a_line_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.last_byte |=> phase_reg == PH_PROG && arg_count_reg == 5'd0
            && byte_pos_reg == 8'd0)
        else $error("line state not cleared after last byte");

    a_arg_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        arg_count_reg <= ARG_MAX)
        else $error("argument count beyond limit");

    a_done_has_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DONE |-> arg_count_reg >= ARG_MAX || byte_pos_reg >= LAST_POS)
        else $error("scan stopped without limit or overlong line");

    a_prog_no_value: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.is_program_name |-> res.arg_index == 5'd0 && !res.has_value
            && res.value_number == 32'd0)
        else $error("program name reported with argument fields");

    a_acc_neg_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_neg_reg == 32'd0 - acc_reg)
        else $error("negated accumulator out of step");

endmodule

FILE: design/blt_out_reg.sv
// Result register: holds one finished token until the downstream side takes it.
module blt_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             res_valid,
    input  blt_pkg::result_t res,
    input  logic             m_ready,
    output logic             m_valid,
    output blt_pkg::result_t m_res,
    output logic             stall
);

    logic             valid_reg, valid_next;
    blt_pkg::result_t res_reg;

    // hold the pipe only while a result waits and nobody takes it
    assign stall      = valid_reg && !m_ready;
    assign valid_next = stall ? 1'b1 : res_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    a_no_load_while_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> valid_reg && res_reg == $past(res_reg))
        else $error("waiting result overwritten");

    a_taken_or_refilled: assert property (@(posedge aclk) disable iff (!aresetn)
        !stall && !res_valid |=> !valid_reg)
        else $error("result shown twice");

    a_new_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        !stall && res_valid |=> valid_reg && res_reg == $past(res))
        else $error("finished token lost");

endmodule

FILE: design/boot_arg_line_tokenizer_unit.sv
// Top level of the boot argument line tokenizer: input register, scanner and result register.
//
// Takes a boot command line one byte per item on the s_ side (s_tlast on the final
// byte) and reports one item on the m_ side for each finished token: first the
// program name (m_tuser high), then each space-delimited argument with its name
// span, the span of the value after the latest '=' that has a following byte, and
// that value read as a wrapping 32-bit integer ('-' sign, "0x" hex). A second space
// in a row yields an empty argument; after the argument limit the rest of the line
// is skipped, and a byte at the last line offset ends the line early. The block
// takes one byte per cycle, back to back: a byte is held in the input register,
// then the scanner updates the line state and loads the result register in the
// same cycle, so a token shows on m_tvalid once its ending byte has passed both
// registers. The only thing that slows intake is the result register: while a
// result waits on m_tready the pipe holds, and the input register still takes one
// more byte.
module boot_arg_line_tokenizer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [4:0] arg_index, [12:5] name_start,
                                   // [20:13] name_length, [21] has_value,
                                   // [29:22] value_start, [37:30] value_length,
                                   // [69:38] value_number, [71:70] zero
    output logic        m_tuser    // is_program_name
);

    logic               in_valid_reg;
    blt_pkg::in_item_t  in_item_reg;
    logic               stall;
    logic               fire;
    blt_pkg::result_t   scan_res;
    logic               scan_valid;
    blt_pkg::result_t   out_res;

    // take a byte when the input register is empty or moves on this cycle
    assign s_tready = !in_valid_reg || !stall;
    assign fire     = in_valid_reg && !stall;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.data_byte <= s_tdata;
            in_item_reg.last_byte <= s_tlast;
        end
    end

    blt_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (in_item_reg),
        .res       (scan_res),
        .res_valid (scan_valid)
    );

    blt_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (scan_valid),
        .res       (scan_res),
        .m_ready   (m_tready),
        .m_valid   (m_tvalid),
        .m_res     (out_res),
        .stall     (stall)
    );

    // pack the result fields, highest field first
    assign m_tdata = {2'b00,
                      out_res.value_number,
                      out_res.value_length,
                      out_res.value_start,
                      out_res.has_value,
                      out_res.name_length,
                      out_res.name_start,
                      out_res.arg_index};
    assign m_tuser = out_res.is_program_name;

    a_hold_input_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && stall |=> in_valid_reg && in_item_reg == $past(in_item_reg))
        else $error("buffered byte dropped during stall");

    a_result_only_from_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_valid |-> fire)
        else $error("result raised without a byte");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[71:70] == 2'b00)
        else $error("pad bits not zero");

endmodule
